/* rtl/bcft_pkg.sv */
// ----------------------------------------------------------------------------
// bcft_pkg
// shared types and constants of the bezier frame tessellator
// ----------------------------------------------------------------------------
package bcft_pkg;

  localparam logic [5:0]  MAX_STEPS = 6'd63;
  localparam logic [5:0]  STEP_RESET = 6'd16;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // iterative divider geometry
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 32;

  typedef logic signed [47:0] wide_t;
  typedef logic signed [15:0] q14_t;

  // one segment job handed from the front to the back
  typedef struct packed {
    logic [3:0][2:0][31:0] w;
    logic [5:0]            n;
    logic                  seg;
    logic                  bad;
  } job_t;

  // one result item
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [47:0]      tangent;
    logic [47:0]      normal_vec;
    logic [47:0]      binormal;
    logic             last_of_run;
    logic             malformed;
  } res_t;

endpackage

/* rtl/bcft_fifo.sv */
// ----------------------------------------------------------------------------
// bcft_fifo
// small register queue used between the parts of the tessellator
// ----------------------------------------------------------------------------
module bcft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr;
  logic [AW-1:0]    rd;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wr <= (wr == AW'(DEPTH - 1)) ? '0 : wr + AW'(1);
      end
      if (do_pop) begin
        rd <= (rd == AW'(DEPTH - 1)) ? '0 : rd + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

/* rtl/bcft_div.sv */
// ----------------------------------------------------------------------------
// bcft_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bcft_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcft_pkg::DIV_NW-1:0] num,
  input  logic [bcft_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [bcft_pkg::DIV_NW-1:0] quo,
  output logic [bcft_pkg::DIV_DW-1:0] rem
);
  import bcft_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_DW-1:0] dv;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DIV_NW-1]};
  assign fits  = (trial >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num;
        rem  <= '0;
        dv   <= den;
        cnt  <= CW'(DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_DW'(trial - {1'b0, dv});
          quo <= {quo[DIV_NW-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/bcft_unit.sv */
// ----------------------------------------------------------------------------
// bcft_unit
// vector normalizer: scale down, sum of squares, integer root, three divides
// ----------------------------------------------------------------------------
module bcft_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bcft_pkg::wide_t vec [3],
  output logic            done,
  output bcft_pkg::q14_t  uout [3]
);
  import bcft_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE, U_SHIFT, U_SQ, U_ROOT, U_DIV, U_WAIT
  } ustate_t;

  ustate_t     state;
  logic [47:0] a [3];
  logic [2:0]  neg;
  logic [1:0]  k;
  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [59:0] sq;
  logic [63:0] trial;
  logic        ge;
  logic        big;
  logic        zero;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;
  logic [15:0]       q16;

  assign sq    = 60'(a[k][29:0]) * 60'(a[k][29:0]);
  assign trial = r + bitv;
  assign ge    = (x >= trial);
  assign big   = |(a[0][47:30] | a[1][47:30] | a[2][47:30]);
  assign zero  = (a[0] == '0) && (a[1] == '0) && (a[2] == '0);

  // rounded quotient: (a * 2^14 + len / 2) / len
  assign div_start = (state == U_DIV);
  assign div_num   = DIV_NW'({a[k][29:0], 14'b0}) + DIV_NW'(r[31:1]);
  assign div_den   = r[31:0];
  assign q16       = div_quo[15:0];

  bcft_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              a[i]   <= vec[i][47] ? 48'(-vec[i]) : 48'(vec[i]);
              neg[i] <= vec[i][47];
            end
            state <= U_SHIFT;
          end
        end
        U_SHIFT: begin
          if (zero) begin
            for (int i = 0; i < 3; i++) begin
              uout[i] <= '0;
            end
            done  <= 1'b1;
            state <= U_IDLE;
          end else if (big) begin
            for (int i = 0; i < 3; i++) begin
              a[i] <= a[i] >> 1;
            end
          end else begin
            k     <= '0;
            x     <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          x <= x + 64'(sq);
          if (k == 2'd2) begin
            k     <= '0;
            r     <= '0;
            bitv  <= 64'h4000_0000_0000_0000;
            state <= U_ROOT;
          end else begin
            k <= k + 2'd1;
          end
        end
        U_ROOT: begin
          if (ge) begin
            x <= x - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            state <= U_DIV;
          end
        end
        U_DIV: begin
          state <= U_WAIT;
        end
        U_WAIT: begin
          if (div_done) begin
            uout[k] <= neg[k] ? -q16 : q16;
            if (k == 2'd2) begin
              k     <= '0;
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= U_DIV;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bcft_front.sv */
// ----------------------------------------------------------------------------
// bcft_front
// takes control points, keeps the point window and issues segment jobs
// ----------------------------------------------------------------------------
module bcft_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic               end_of_curve,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data,
  input  logic               job_full,
  output logic               job_push,
  output bcft_pkg::job_t     job
);
  import bcft_pkg::*;

  logic [2:0][2:0][31:0] win;
  logic [1:0]            held;
  logic                  seen;
  logic [5:0]            step_count;

  logic                  accepted;
  logic                  seg;
  logic [1:0]            held_a;
  logic                  seen_a;
  logic                  bad;
  logic [2:0][31:0]      p;

  assign cfg_ready = 1'b1;
  assign full      = job_full;
  assign accepted  = push && !full;
  assign p         = {pz, py, px};

  // a fourth point closes a segment
  assign seg    = (held == 2'd3);
  assign held_a = seg ? 2'd1 : held + 2'd1;
  assign seen_a = seg || seen;
  // well-formed end holds only the shared end point of an emitted segment
  assign bad    = end_of_curve && !((held_a == 2'd1) && seen_a);

  assign job_push = accepted && (seg || bad);
  assign job.w    = {p, win[2], win[1], win[0]};
  assign job.n    = step_count;
  assign job.seg  = seg;
  assign job.bad  = bad;

  always_ff @(posedge clk) begin
    if (accepted) begin
      if (seg) begin
        win[0] <= p;
      end else begin
        win[held] <= p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      seen       <= 1'b0;
      step_count <= STEP_RESET;
    end else begin
      if (cfg_valid) begin
        step_count <= cfg_data;
      end
      if (accepted) begin
        if (end_of_curve) begin
          held <= '0;
          seen <= 1'b0;
        end else begin
          held <= held_a;
          seen <= seen_a;
        end
      end
    end
  end

endmodule

/* rtl/bcft_back.sv */
// ----------------------------------------------------------------------------
// bcft_back
// segment evaluator: positions, derivative and moving frame per step
// ----------------------------------------------------------------------------
module bcft_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  bcft_pkg::job_t job,
  output logic           job_pop,
  input  logic           res_full,
  output logic           res_push,
  output bcft_pkg::res_t res
);
  import bcft_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_NN, S_DEN, S_UT0, S_UN0, S_PUT, S_WGT1, S_WGT2, S_MAC,
    S_PDIV, S_PDIVW, S_UD, S_CR1, S_UN, S_CR2, S_UB, S_BAD
  } state_t;

  state_t             state;
  logic signed [31:0] w [4][3];
  logic signed [32:0] dif [3][3];
  logic [5:0]         n;
  logic               bad;
  logic [5:0]         s;
  logic [11:0]        nn;
  logic [17:0]        den;
  logic [11:0]        a2;
  logic [11:0]        s2;
  logic [11:0]        as_r;
  logic [11:0]        tas;
  logic [17:0]        a3;
  logic [17:0]        wa;
  logic [17:0]        wb;
  logic [17:0]        s3;
  logic [1:0]         c;
  logic [2:0]         j;
  logic signed [53:0] acc;
  logic signed [53:0] psum [3];
  wide_t              dv [3];
  logic signed [31:0] pos [3];
  logic               xneg;
  wide_t              uvec [3];
  q14_t               tu [3];
  q14_t               nu [3];
  q14_t               bq [3];
  logic               ubusy;

  logic [5:0]         n_c;
  logic [5:0]         av;
  logic [17:0]        t_a2s;
  logic [17:0]        t_ass;
  logic [17:0]        coef;
  logic signed [32:0] val;
  logic signed [53:0] prod;
  logic signed [53:0] acc_new;
  logic signed [54:0] xs;
  logic [54:0]        xmag;
  logic [31:0]        qq;

  logic               ustart;
  logic               udone;
  q14_t               uout [3];
  logic               div_start;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic               div_done;
  logic [DIV_NW-1:0]  div_quo;
  logic [DIV_DW-1:0]  div_rem;

  function automatic logic [47:0] pack3(input q14_t v [3]);
    return {v[0], v[1], v[2]};
  endfunction

  // one component of x cross y
  function automatic wide_t cross_c(input q14_t x [3], input q14_t y [3],
                                    input logic [1:0] ci);
    logic [1:0]         i1;
    logic [1:0]         i2;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [32:0] d;
    i1 = (ci == 2'd0) ? 2'd1 : ((ci == 2'd1) ? 2'd2 : 2'd0);
    i2 = (ci == 2'd0) ? 2'd2 : ((ci == 2'd1) ? 2'd0 : 2'd1);
    m1 = 32'(x[i1]) * 32'(y[i2]);
    m2 = 32'(x[i2]) * 32'(y[i1]);
    d  = 33'(m1) - 33'(m2);
    return 48'(d);
  endfunction

  assign n_c   = (job.n == '0) ? 6'd1 : ((job.n > MAX_STEPS) ? MAX_STEPS : job.n);
  assign av    = n - s;
  assign t_a2s = 18'(a2) * 18'(s);
  assign t_ass = 18'(as_r) * 18'(s);

  // term select: four bernstein terms of position, three of the derivative
  always_comb begin
    coef = '0;
    val  = '0;
    case (j)
      3'd0: begin coef = a3;        val = 33'(w[0][c]); end
      3'd1: begin coef = wa;        val = 33'(w[1][c]); end
      3'd2: begin coef = wb;        val = 33'(w[2][c]); end
      3'd3: begin coef = s3;        val = 33'(w[3][c]); end
      3'd4: begin coef = 18'(a2);   val = dif[0][c];    end
      3'd5: begin coef = 18'(tas);  val = dif[1][c];    end
      3'd6: begin coef = 18'(s2);   val = dif[2][c];    end
      default: begin coef = '0;     val = '0;           end
    endcase
  end

  assign prod    = 54'($signed({1'b0, coef})) * 54'(val);
  assign acc_new = ((j == 3'd0) || (j == 3'd4)) ? prod : acc + prod;

  // rounded position: floor((2 sum + den) / (2 den))
  assign xs        = $signed({psum[c], 1'b0}) + 55'($signed({1'b0, den}));
  assign xmag      = xs[54] ? 55'(-xs) : 55'(xs);
  assign div_start = (state == S_PDIV);
  assign div_num   = xmag[DIV_NW-1:0];
  assign div_den   = DIV_DW'({den, 1'b0});
  assign qq        = div_quo[31:0] + 32'(div_rem != '0);

  assign ustart = ((state == S_UT0) || (state == S_UN0) || (state == S_UD) ||
                   (state == S_UN) || (state == S_UB)) && !ubusy;

  assign job_pop  = (state == S_IDLE) && job_valid;
  assign res_push = (state == S_PUT) && !res_full;

  bcft_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  bcft_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (ustart),
    .vec   (uvec),
    .done  (udone),
    .uout  (uout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ubusy <= 1'b0;
      c     <= '0;
      j     <= '0;
      s     <= '0;
    end else begin
      if (ustart) begin
        ubusy <= 1'b1;
      end else if (udone) begin
        ubusy <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            for (int jj = 0; jj < 4; jj++) begin
              for (int cc = 0; cc < 3; cc++) begin
                w[jj][cc] <= $signed(job.w[jj][cc]);
              end
            end
            for (int jj = 0; jj < 3; jj++) begin
              for (int cc = 0; cc < 3; cc++) begin
                dif[jj][cc] <= 33'($signed(job.w[jj+1][cc])) -
                               33'($signed(job.w[jj][cc]));
              end
            end
            n     <= n_c;
            bad   <= job.bad;
            s     <= '0;
            state <= job.seg ? S_NN : S_BAD;
          end
        end
        S_NN: begin
          nn    <= 12'(n) * 12'(n);
          state <= S_DEN;
        end
        S_DEN: begin
          den <= 18'(nn) * 18'(n);
          for (int cc = 0; cc < 3; cc++) begin
            uvec[cc] <= 48'(dif[0][cc]);
          end
          state <= S_UT0;
        end
        S_UT0: begin
          if (udone) begin
            tu <= uout;
            // start normal is b x t with b = z, or b = y when that is zero
            if ((dif[0][0] == '0) && (dif[0][1] == '0)) begin
              uvec[0] <= 48'(dif[0][2]);
              uvec[1] <= '0;
              uvec[2] <= '0;
              bq[0]   <= '0;
              bq[1]   <= ONE_Q14;
              bq[2]   <= '0;
            end else begin
              uvec[0] <= 48'(-dif[0][1]);
              uvec[1] <= 48'(dif[0][0]);
              uvec[2] <= '0;
              bq[0]   <= '0;
              bq[1]   <= '0;
              bq[2]   <= ONE_Q14;
            end
            state <= S_UN0;
          end
        end
        S_UN0: begin
          if (udone) begin
            nu              <= uout;
            res.pos         <= {w[0][2], w[0][1], w[0][0]};
            res.tangent     <= pack3(tu);
            res.normal_vec  <= pack3(uout);
            res.binormal    <= pack3(bq);
            res.last_of_run <= 1'b0;
            res.malformed   <= 1'b0;
            state           <= S_PUT;
          end
        end
        S_PUT: begin
          if (!res_full) begin
            if (s == n) begin
              state <= bad ? S_BAD : S_IDLE;
            end else begin
              s     <= s + 6'd1;
              state <= S_WGT1;
            end
          end
        end
        S_WGT1: begin
          a2    <= 12'(av) * 12'(av);
          s2    <= 12'(s) * 12'(s);
          as_r  <= 12'(av) * 12'(s);
          state <= S_WGT2;
        end
        S_WGT2: begin
          a3    <= 18'(a2) * 18'(av);
          wa    <= t_a2s + (t_a2s << 1);
          wb    <= t_ass + (t_ass << 1);
          s3    <= 18'(s2) * 18'(s);
          tas   <= as_r << 1;
          c     <= '0;
          j     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          acc <= acc_new;
          if (j == 3'd3) begin
            psum[c] <= acc_new;
          end
          if (j == 3'd6) begin
            dv[c] <= acc_new[47:0];
            j     <= '0;
            if (c == 2'd2) begin
              c     <= '0;
              state <= S_PDIV;
            end else begin
              c <= c + 2'd1;
            end
          end else begin
            j <= j + 3'd1;
          end
        end
        S_PDIV: begin
          xneg  <= xs[54];
          state <= S_PDIVW;
        end
        S_PDIVW: begin
          if (div_done) begin
            pos[c] <= xneg ? -qq : div_quo[31:0];
            if (c == 2'd2) begin
              c     <= '0;
              uvec  <= dv;
              state <= S_UD;
            end else begin
              c     <= c + 2'd1;
              state <= S_PDIV;
            end
          end
        end
        S_UD: begin
          if (udone) begin
            tu    <= uout;
            c     <= '0;
            state <= S_CR1;
          end
        end
        S_CR1: begin
          uvec[c] <= cross_c(bq, tu, c);
          if (c == 2'd2) begin
            c     <= '0;
            state <= S_UN;
          end else begin
            c <= c + 2'd1;
          end
        end
        S_UN: begin
          if (udone) begin
            nu    <= uout;
            state <= S_CR2;
          end
        end
        S_CR2: begin
          uvec[c] <= cross_c(tu, nu, c);
          if (c == 2'd2) begin
            c     <= '0;
            state <= S_UB;
          end else begin
            c <= c + 2'd1;
          end
        end
        S_UB: begin
          if (udone) begin
            bq              <= uout;
            res.pos         <= {pos[2], pos[1], pos[0]};
            res.tangent     <= pack3(tu);
            res.normal_vec  <= pack3(nu);
            res.binormal    <= pack3(uout);
            res.last_of_run <= (s == n) && !bad;
            res.malformed   <= 1'b0;
            state           <= S_PUT;
          end
        end
        S_BAD: begin
          res.pos         <= '0;
          res.tangent     <= '0;
          res.normal_vec  <= '0;
          res.binormal    <= '0;
          res.last_of_run <= 1'b1;
          res.malformed   <= 1'b1;
          bad             <= 1'b0;
          s               <= n;
          state           <= S_PUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bezier_curve_frame_tessellator_unit.sv */
// ----------------------------------------------------------------------------
// bezier_curve_frame_tessellator_unit
// cubic bezier tessellator emitting points with a tangent/normal/binormal frame
// ----------------------------------------------------------------------------
// control points enter one per cycle through push/full while full is low;
// every third new point after the first closes a cubic segment and yields
// step_count + 1 result items (the segment start and the evaluated points,
// with a step_count of 0 taken as 1), a curve end off the 3n+1 boundary
// yields one malformed item. points that close no segment only update the
// point window at the front. the back works one evaluated point at a time;
// per point it runs three position divides and nine quotient divides on the
// one-bit-per-cycle divider, three integer roots and the scale-down shifts
// of the normalizer. a segment's start item takes two normalizer passes. a
// two-entry job queue lets the front take points while the back is busy, and
// a result queue holds finished items until popped. no clearing pass on reset.
module bezier_curve_frame_tessellator_unit #(
  parameter int JOB_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  // control point input
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic               end_of_curve,
  // result output
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [47:0]        tangent,
  output logic [47:0]        normal_vec,
  output logic [47:0]        binormal,
  output logic               last_of_run,
  output logic               malformed,
  // step_count register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);
  import bcft_pkg::*;

  // front to job queue
  logic job_push;
  logic job_full;
  job_t job_in;
  // job queue to back
  logic job_pop;
  logic job_empty;
  job_t job_out;
  // back to result queue
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  bcft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .px           (px),
    .py           (py),
    .pz           (pz),
    .end_of_curve (end_of_curve),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .job_full     (job_full),
    .job_push     (job_push),
    .job          (job_in)
  );

  // segment jobs waiting for the back
  bcft_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  bcft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // finished items waiting to be popped
  bcft_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign pos_x       = $signed(res_out.pos[0]);
  assign pos_y       = $signed(res_out.pos[1]);
  assign pos_z       = $signed(res_out.pos[2]);
  assign tangent     = res_out.tangent;
  assign normal_vec  = res_out.normal_vec;
  assign binormal    = res_out.binormal;
  assign last_of_run = res_out.last_of_run;
  assign malformed   = res_out.malformed;

endmodule
